// ===== hdl/plir_pkg.sv =====
// ----------------------------------------------------------------------------
// plir_pkg
// Shared types, constants and helpers for the packet loss injector relay.
// ----------------------------------------------------------------------------
`default_nettype none

package plir_pkg;

    // counter and idle widths
    localparam int COUNTER_BITS = 32;
    localparam int IDLE_BITS    = 8;

    // field widths fixed by the item formats
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int THRESH_W  = 17;
    localparam int TIMEOUT_W = 8;
    localparam int SEED_W    = 32;
    localparam int OUT_CNT_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // width used for the idle timeout compare
    localparam int CMP_W = (IDLE_BITS > TIMEOUT_W) ? IDLE_BITS : TIMEOUT_W;
    // width used to widen a counter to the output width
    localparam int CNT_EXT_W = (COUNTER_BITS > OUT_CNT_W) ? COUNTER_BITS : OUT_CNT_W;

    // lfsr feedback taps and reset seed
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'hD000_0001;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'h0000_0001;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RCV_IP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RCV_PORT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED    = 3'd4;

    // item kinds
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // result actions
    typedef enum logic [2:0] {
        ACT_TO_RCV = 3'd0,
        ACT_TO_SND = 3'd1,
        ACT_DROP   = 3'd2,
        ACT_IGNORE = 3'd3,
        ACT_TICK   = 3'd4,
        ACT_DONE   = 3'd5
    } action_t;

    // input word
    typedef struct packed {
        logic              op;
        logic [IP_W-1:0]   src_ip;
        logic [PORT_W-1:0] src_port;
    } in_item_t;

    // result word
    typedef struct packed {
        action_t              action;
        logic                 from_sender;
        logic [OUT_CNT_W-1:0] fwd_to_receiver_count;
        logic [OUT_CNT_W-1:0] fwd_to_sender_count;
        logic [OUT_CNT_W-1:0] drop_to_receiver_count;
        logic [OUT_CNT_W-1:0] drop_to_sender_count;
    } out_item_t;

    // configuration seen by the decision logic
    typedef struct packed {
        logic [THRESH_W-1:0]  loss_threshold;
        logic [IP_W-1:0]      rcv_ip;
        logic [PORT_W-1:0]    rcv_port;
        logic [TIMEOUT_W-1:0] idle_timeout_ticks;
        logic                 seed_load;
        logic [SEED_W-1:0]    seed_value;
    } cfg_t;

    // low output bits of a counter, zero extended when narrower
    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNTER_BITS-1:0] c);
        logic [CNT_EXT_W-1:0] ext;
        ext = CNT_EXT_W'(c);
        return ext[OUT_CNT_W-1:0];
    endfunction

    // saturating increment
    function automatic logic [COUNTER_BITS-1:0] cnt_bump(input logic [COUNTER_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/plir_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// plir_cfg_regs
// Configuration register file; a seed write also produces a load strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module plir_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [plir_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [plir_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output plir_pkg::cfg_t                           cfg
);

    logic [plir_pkg::THRESH_W-1:0]  thresh_reg,  thresh_next;
    logic [plir_pkg::IP_W-1:0]      rcv_ip_reg,  rcv_ip_next;
    logic [plir_pkg::PORT_W-1:0]    rcv_port_reg, rcv_port_next;
    logic [plir_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                           seed_load;

    // register decode
    always_comb begin
        thresh_next   = thresh_reg;
        rcv_ip_next   = rcv_ip_reg;
        rcv_port_next = rcv_port_reg;
        timeout_next  = timeout_reg;
        seed_load     = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                plir_pkg::REG_LOSS_THRESHOLD: begin
                    thresh_next = cfg_wr_data[plir_pkg::THRESH_W-1:0];
                end
                plir_pkg::REG_RCV_IP: begin
                    rcv_ip_next = cfg_wr_data[plir_pkg::IP_W-1:0];
                end
                plir_pkg::REG_RCV_PORT: begin
                    rcv_port_next = cfg_wr_data[plir_pkg::PORT_W-1:0];
                end
                plir_pkg::REG_IDLE_TIMEOUT: begin
                    timeout_next = cfg_wr_data[plir_pkg::TIMEOUT_W-1:0];
                end
                plir_pkg::REG_RANDOM_SEED: begin
                    seed_load = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= '0;
            rcv_ip_reg   <= '0;
            rcv_port_reg <= '0;
            timeout_reg  <= plir_pkg::TIMEOUT_RESET;
        end else begin
            thresh_reg   <= thresh_next;
            rcv_ip_reg   <= rcv_ip_next;
            rcv_port_reg <= rcv_port_next;
            timeout_reg  <= timeout_next;
        end
    end

    // a zero seed would lock the lfsr, load it as one
    always_comb begin
        cfg.loss_threshold     = thresh_reg;
        cfg.rcv_ip             = rcv_ip_reg;
        cfg.rcv_port           = rcv_port_reg;
        cfg.idle_timeout_ticks = timeout_reg;
        cfg.seed_load          = seed_load;
        cfg.seed_value         = (cfg_wr_data[plir_pkg::SEED_W-1:0] == '0) ?
                                 plir_pkg::SEED_RESET : cfg_wr_data[plir_pkg::SEED_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/plir_decide.sv =====
// ----------------------------------------------------------------------------
// plir_decide
// Relay state and per-word decision: routing, loss lfsr, idle timeout and
// saturating counters. State advances on step; result is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module plir_decide (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire plir_pkg::in_item_t  item,
    input  wire plir_pkg::cfg_t      cfg,
    output plir_pkg::out_item_t      result
);

    localparam int CmpW = plir_pkg::CMP_W;

    logic                              active_reg,  active_next;
    logic [plir_pkg::IP_W-1:0]         snd_ip_reg,  snd_ip_next;
    logic [plir_pkg::PORT_W-1:0]       snd_port_reg, snd_port_next;
    logic [plir_pkg::IDLE_BITS-1:0]    idle_reg,    idle_next;
    logic [plir_pkg::SEED_W-1:0]       lfsr_reg,    lfsr_next;
    logic [plir_pkg::COUNTER_BITS-1:0] fwd_s2r_reg, fwd_s2r_next;
    logic [plir_pkg::COUNTER_BITS-1:0] fwd_r2s_reg, fwd_r2s_next;
    logic [plir_pkg::COUNTER_BITS-1:0] drp_s2r_reg, drp_s2r_next;
    logic [plir_pkg::COUNTER_BITS-1:0] drp_r2s_reg, drp_r2s_next;

    logic [plir_pkg::IDLE_BITS-1:0] idle_inc;
    logic [CmpW-1:0]                idle_ext;
    logic [CmpW-1:0]                timeout_ext;
    logic [plir_pkg::SEED_W-1:0]    lfsr_step;
    logic                           lose;
    logic                           snd_match;
    logic                           rcv_match;
    logic                           toward_rcv;
    logic                           routed;
    plir_pkg::action_t              action;
    logic                           from_snd;

    // shared decision terms
    always_comb begin
        idle_inc    = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
        idle_ext    = CmpW'(idle_inc);
        timeout_ext = CmpW'(cfg.idle_timeout_ticks);
        lfsr_step   = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? plir_pkg::LFSR_TAPS : '0);
        lose        = {1'b0, lfsr_step[plir_pkg::SEED_W-1:16]} < cfg.loss_threshold;
        snd_match   = (item.src_ip == snd_ip_reg) && (item.src_port == snd_port_reg);
        rcv_match   = (item.src_ip == cfg.rcv_ip) &&
                      (item.src_port == cfg.rcv_port);
        toward_rcv  = !active_reg || snd_match;
        routed      = toward_rcv || rcv_match;
    end

    // next state and result
    always_comb begin
        active_next   = active_reg;
        snd_ip_next   = snd_ip_reg;
        snd_port_next = snd_port_reg;
        idle_next     = idle_reg;
        lfsr_next     = lfsr_reg;
        fwd_s2r_next  = fwd_s2r_reg;
        fwd_r2s_next  = fwd_r2s_reg;
        drp_s2r_next  = drp_s2r_reg;
        drp_r2s_next  = drp_r2s_reg;
        action        = plir_pkg::ACT_TICK;
        from_snd      = 1'b0;

        if (item.op == plir_pkg::OP_TICK) begin
            idle_next = idle_inc;
            if (active_reg && (idle_ext >= timeout_ext)) begin
                active_next = 1'b0;
                action      = plir_pkg::ACT_DONE;
            end
        end else begin
            idle_next = '0;
            // first packet while inactive claims the sender slot
            if (!active_reg) begin
                snd_ip_next   = item.src_ip;
                snd_port_next = item.src_port;
                active_next   = 1'b1;
            end
            if (!routed) begin
                action = plir_pkg::ACT_IGNORE;
            end else begin
                from_snd  = toward_rcv;
                lfsr_next = lfsr_step;
                if (lose) begin
                    action = plir_pkg::ACT_DROP;
                    if (toward_rcv) begin
                        drp_s2r_next = plir_pkg::cnt_bump(drp_s2r_reg);
                    end else begin
                        drp_r2s_next = plir_pkg::cnt_bump(drp_r2s_reg);
                    end
                end else if (toward_rcv) begin
                    action       = plir_pkg::ACT_TO_RCV;
                    fwd_s2r_next = plir_pkg::cnt_bump(fwd_s2r_reg);
                end else begin
                    action       = plir_pkg::ACT_TO_SND;
                    fwd_r2s_next = plir_pkg::cnt_bump(fwd_r2s_reg);
                end
            end
        end

        result.action                 = action;
        result.from_sender            = from_snd;
        result.fwd_to_receiver_count  = plir_pkg::cnt_out(fwd_s2r_next);
        result.fwd_to_sender_count    = plir_pkg::cnt_out(fwd_r2s_next);
        result.drop_to_receiver_count = plir_pkg::cnt_out(drp_s2r_next);
        result.drop_to_sender_count   = plir_pkg::cnt_out(drp_r2s_next);
    end

    // relay state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            snd_ip_reg   <= '0;
            snd_port_reg <= '0;
            idle_reg     <= '0;
            lfsr_reg     <= plir_pkg::SEED_RESET;
            fwd_s2r_reg  <= '0;
            fwd_r2s_reg  <= '0;
            drp_s2r_reg  <= '0;
            drp_r2s_reg  <= '0;
        end else if (cfg.seed_load) begin
            lfsr_reg <= cfg.seed_value;
        end else if (step) begin
            active_reg   <= active_next;
            snd_ip_reg   <= snd_ip_next;
            snd_port_reg <= snd_port_next;
            idle_reg     <= idle_next;
            lfsr_reg     <= lfsr_next;
            fwd_s2r_reg  <= fwd_s2r_next;
            fwd_r2s_reg  <= fwd_r2s_next;
            drp_s2r_reg  <= drp_s2r_next;
            drp_r2s_reg  <= drp_r2s_next;
        end
    end

    // lfsr never locks up at zero
    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("loss lfsr reached zero");

    // a packet always leaves the link active
    a_packet_activates: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.seed_load && (item.op == plir_pkg::OP_PACKET) |=> active_reg)
        else $error("link inactive after packet");

    // completion deactivates the link
    a_done_deactivates: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.seed_load && (action == plir_pkg::ACT_DONE) |=> !active_reg)
        else $error("link still active after completion");

    // the lfsr only moves on a routed packet or a seed load
    a_lfsr_moves_on_route: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg.seed_load && !(step && (item.op == plir_pkg::OP_PACKET) && routed)
        |=> $stable(lfsr_reg))
        else $error("lfsr stepped without a routed packet");

    // forwarded counter toward receiver never goes backward
    a_fwd_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fwd_s2r_reg >= $past(fwd_s2r_reg))
        else $error("forward counter decreased");

endmodule

`default_nettype wire

// ===== hdl/packet_loss_injector_relay_unit.sv =====
// ----------------------------------------------------------------------------
// packet_loss_injector_relay_unit
// Two-party relay decision engine with lfsr based loss injection.
// ----------------------------------------------------------------------------
// Path: a word accepted into the input register is decided and captured in
//   the result register. Throughput: one word per cycle while m_ready is
//   high; input register, decision logic, result register, with ready
//   passed back so both registers fill when stalled.
// Reset: synchronous active-low aresetn clears the relay state, counters and
//   pipeline valids, loads the lfsr with one and restores register defaults.
`default_nettype none

module packet_loss_injector_relay_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [plir_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [plir_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire plir_pkg::in_item_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output plir_pkg::out_item_t                  m_item
);

    plir_pkg::cfg_t      cfg;
    plir_pkg::in_item_t  in_item_reg;
    plir_pkg::out_item_t out_item_reg;
    plir_pkg::out_item_t result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                step;

    plir_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    plir_decide u_decide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // pipeline handshake
    always_comb begin
        out_free       = !out_valid_reg || m_ready;
        step           = in_valid_reg && out_free;
        s_ready        = !in_valid_reg || out_free;
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result words
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

`default_nettype wire
